### rtl/tprc_pkg.sv
package tprc_pkg;

    localparam int MAX_PAGES_DEF  = 16;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_ENTRY = 3'd3;
    localparam logic [2:0] REQ_BYTE  = 3'd4;

    localparam logic [1:0] REG_DATA    = 2'd0;
    localparam logic [1:0] REG_STATUS  = 2'd1;
    localparam logic [1:0] REG_CONTROL = 2'd2;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    localparam logic [2:0] CFG_PAGE_COUNT = 3'd0;
    localparam logic [2:0] CFG_SEEK_STEP  = 3'd1;
    localparam logic [2:0] CFG_FIRST_BYTE = 3'd2;
    localparam logic [2:0] CFG_BYTE       = 3'd3;
    localparam logic [2:0] CFG_BIT_PROC   = 3'd4;

    localparam logic [7:0] CMD_NEXT_SLOT = 8'h86;
    localparam logic [7:0] CMD_FWD_MAX   = 8'h3F;
    localparam logic [7:0] CMD_BACK_MAX  = 8'h7F;
    localparam logic [7:0] BYTE_NONE     = 8'hAA;

    localparam int F_IN_DATA    = 0;
    localparam int F_READY      = 1;
    localparam int F_MOTOR_OFF  = 2;
    localparam int F_PAGE_FOUND = 3;
    localparam int F_DECODER    = 4;
    localparam int F_IRQ_EN     = 5;

    typedef struct packed {
        logic [31:0] lead_in;
        logic [12:0] length;
        logic [7:0]  page_number;
    } entry_t;

endpackage

### rtl/tprc_table.sv
module tprc_table #(
    parameter int MAX_PAGES = tprc_pkg::MAX_PAGES_DEF,
    parameter int SW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [SW-1:0]         wr_addr,
    input  tprc_pkg::entry_t      wr_data,
    input  logic [SW-1:0]         rd_addr,
    output tprc_pkg::entry_t      rd_data
);
    tprc_pkg::entry_t mem [MAX_PAGES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### rtl/tprc_bytes.sv
module tprc_bytes #(
    parameter int DEPTH = tprc_pkg::MAX_PAGES_DEF * tprc_pkg::PAGE_BYTES_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### rtl/tape_page_reader_controller.sv
// Without a table search an item takes a memory read, then the update.
// A tick that ends a seek step adds a table search, over at most the pages in use,
// and then a fetch; a command that moves to the next slot adds the fetch alone.
// A new item is taken only when idle and no earlier result is held back.
// Reset is synchronous and active low; it restores the control registers and
// configuration defaults, while the table and byte memories keep their contents.
module tape_page_reader_controller #(
    parameter int MAX_PAGES  = tprc_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = tprc_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[2:0], reg_index[4:3], write_data[12:5], entry_index[16:13],
    // entry_lead_in_cycles[48:17], entry_length[61:49],
    // entry_page_number[69:62], byte_offset[81:70], zeros up to 87
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], irq_asserted[8], zeros up to 15
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_data
);
    localparam int SW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int OW  = $clog2(PAGE_BYTES);
    localparam int AW  = SW + OW;
    localparam int CW  = $clog2(MAX_PAGES + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FETCH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  req;
    logic [1:0]  rix;
    logic [7:0]  wdat;
    logic [3:0]  eix;
    logic [11:0] boff;
    assign req  = s_tdata[2:0];
    assign rix  = s_tdata[4:3];
    assign wdat = s_tdata[12:5];
    assign eix  = s_tdata[16:13];
    assign boff = s_tdata[81:70];

    logic [87:0] item_reg;
    logic [2:0]  i_req;
    logic [1:0]  i_rix;
    logic [7:0]  i_wdat;
    assign i_req  = item_reg[2:0];
    assign i_rix  = item_reg[4:3];
    assign i_wdat = item_reg[12:5];

    logic [4:0]  page_count_reg;
    logic [21:0] seek_step_reg;
    logic [15:0] first_byte_reg, byte_cyc_reg, bit_proc_reg;

    logic [7:0]  control_prev_reg, cmd_shift_reg, current_page_reg;
    logic [2:0]  cmd_bits_reg;
    logic [15:0] seek_target_reg;
    logic [21:0] seek_cd_reg;
    logic [15:0] byte_cd_reg, bit_cd_reg;
    logic [31:0] lead_cd_reg;
    logic [SW-1:0] slot_reg;
    logic [13:0] byte_pos_reg;
    logic [5:0]  flags_reg;
    logic        irq_reg;
    logic [CW-1:0] search_reg;
    logic        found_reg;
    logic [15:0] out_reg;
    logic        out_valid_reg;

    // Page table and byte memories.
    logic             tab_we;
    logic [SW-1:0]    tab_waddr, tab_raddr;
    tprc_pkg::entry_t tab_wdata, tab_rdata;
    logic             byte_we;
    logic [AW-1:0]    byte_waddr, byte_raddr;
    logic [7:0]       byte_rdata;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && !(out_valid_reg && !m_tready);
    assign accept   = s_tvalid && s_tready;

    logic eix_ok, boff_ok;
    assign eix_ok  = 32'(eix) < 32'(MAX_PAGES);
    assign boff_ok = 32'(boff) < 32'(PAGE_BYTES);

    assign tab_we    = accept && req == tprc_pkg::REQ_ENTRY && eix_ok;
    assign tab_waddr = SW'(eix);
    assign tab_wdata = '{lead_in: s_tdata[48:17], length: s_tdata[61:49],
                         page_number: s_tdata[69:62]};
    assign byte_we    = accept && req == tprc_pkg::REQ_BYTE && eix_ok && boff_ok;
    assign byte_waddr = {SW'(eix), OW'(boff)};

    logic [4:0]    pages_in_use;
    assign pages_in_use = (page_count_reg == 5'd0) ? 5'd1 :
        ((32'(page_count_reg) > 32'(MAX_PAGES)) ? 5'(MAX_PAGES) : page_count_reg);

    assign byte_raddr = {slot_reg, OW'(byte_pos_reg)};

    tprc_table #(.MAX_PAGES(MAX_PAGES), .SW(SW)) u_table (
        .aclk(aclk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
        .rd_addr(tab_raddr), .rd_data(tab_rdata)
    );

    tprc_bytes #(.DEPTH(MAX_PAGES * PAGE_BYTES), .AW(AW)) u_bytes (
        .aclk(aclk), .wr_en(byte_we), .wr_addr(byte_waddr), .wr_data(wdat),
        .rd_addr(byte_raddr), .rd_data(byte_rdata)
    );

    // Next state of the controller.
    logic [7:0]  control_prev_next, cmd_shift_next, current_page_next;
    logic [2:0]  cmd_bits_next;
    logic [15:0] seek_target_next;
    logic [21:0] seek_cd_next;
    logic [15:0] byte_cd_next, bit_cd_next;
    logic [31:0] lead_cd_next;
    logic [SW-1:0] slot_next;
    logic [13:0] byte_pos_next;
    logic [5:0]  flags_next;
    logic        irq_next;
    logic [CW-1:0] search_next;
    logic        found_next;
    logic [15:0] out_next;
    logic        out_valid_next;

    logic [7:0]  sh, cmd, rd;
    logic [2:0]  nb;
    logic signed [16:0] seek_v, cur_v;
    logic [13:0] bp1;
    logic        in_range;

    always_comb begin
        state_next        = state_reg;
        control_prev_next = control_prev_reg;
        cmd_shift_next    = cmd_shift_reg;
        cmd_bits_next     = cmd_bits_reg;
        current_page_next = current_page_reg;
        seek_target_next  = seek_target_reg;
        seek_cd_next      = seek_cd_reg;
        byte_cd_next      = byte_cd_reg;
        bit_cd_next       = bit_cd_reg;
        lead_cd_next      = lead_cd_reg;
        slot_next         = slot_reg;
        byte_pos_next     = byte_pos_reg;
        flags_next        = flags_reg;
        irq_next          = irq_reg;
        search_next       = search_reg;
        found_next        = found_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        rd                = 8'd0;
        sh                = 8'd0;
        cmd               = 8'd0;
        nb                = 3'd0;
        bp1               = 14'(byte_pos_reg + 14'd1);
        seek_v            = 17'(signed'(seek_target_reg));
        cur_v             = signed'({9'd0, current_page_reg});
        in_range          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                unique case (i_req)
                    tprc_pkg::REQ_TICK: begin
                        if (bit_cd_reg != 16'd0) begin
                            bit_cd_next = bit_cd_reg - 16'd1;
                            if (bit_cd_reg == 16'd1) begin
                                flags_next[tprc_pkg::F_READY] = 1'b1;
                            end
                        end
                        if (!flags_reg[tprc_pkg::F_MOTOR_OFF]) begin
                            if (seek_v != cur_v) begin
                                seek_cd_next = seek_cd_reg - 22'd1;
                                if (seek_cd_reg == 22'd1) begin
                                    seek_cd_next = seek_step_reg;
                                    if (seek_v > cur_v) begin
                                        current_page_next = current_page_reg + 8'd1;
                                    end else begin
                                        current_page_next = current_page_reg - 8'd1;
                                    end
                                    search_next = '0;
                                    found_next  = 1'b0;
                                    slot_next   = '0;
                                    state_next  = ST_SEARCH;
                                end
                            end else if (lead_cd_reg != 32'd0) begin
                                flags_next[tprc_pkg::F_IN_DATA] = 1'b1;
                                lead_cd_next = lead_cd_reg - 32'd1;
                                if (lead_cd_reg == 32'd1) begin
                                    byte_cd_next = first_byte_reg;
                                    irq_next = 1'b1;
                                end
                            end else if (byte_cd_reg != 16'd0) begin
                                byte_cd_next = byte_cd_reg - 16'd1;
                                if (byte_cd_reg == 16'd1) begin
                                    byte_cd_next  = byte_cyc_reg;
                                    byte_pos_next = bp1;
                                    if (!bp1[13] && bp1 >= {1'b0, tab_rdata.length}) begin
                                        flags_next[tprc_pkg::F_PAGE_FOUND] = 1'b0;
                                        flags_next[tprc_pkg::F_IN_DATA]    = 1'b0;
                                        flags_next[tprc_pkg::F_MOTOR_OFF]  = 1'b1;
                                    end
                                    if (flags_reg[tprc_pkg::F_IRQ_EN]) begin
                                        irq_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    tprc_pkg::REQ_READ: begin
                        unique case (i_rix)
                            tprc_pkg::REG_DATA: begin
                                irq_next = 1'b0;
                                in_range = !byte_pos_reg[13]
                                    && byte_pos_reg < {1'b0, tab_rdata.length}
                                    && 32'(byte_pos_reg) < 32'(PAGE_BYTES);
                                rd = in_range ? byte_rdata : tprc_pkg::BYTE_NONE;
                            end
                            tprc_pkg::REG_STATUS: begin
                                rd = {flags_reg[tprc_pkg::F_DECODER],
                                      flags_reg[tprc_pkg::F_PAGE_FOUND],
                                      flags_reg[tprc_pkg::F_IN_DATA], 5'h10};
                                flags_next[tprc_pkg::F_PAGE_FOUND] = 1'b0;
                            end
                            tprc_pkg::REG_CONTROL: begin
                                rd = flags_reg[tprc_pkg::F_READY] ? 8'h40 : 8'h00;
                            end
                            tprc_pkg::REG_SPARE: begin
                                rd = 8'd0;
                            end
                        endcase
                    end
                    tprc_pkg::REQ_WRITE: begin
                        if (i_rix == tprc_pkg::REG_CONTROL) begin
                            if (control_prev_reg[4] && !i_wdat[4]) begin
                                sh = {cmd_shift_reg[6:0], i_wdat[7]};
                                nb = cmd_bits_reg + 3'd1;
                                cmd_shift_next = sh;
                                cmd_bits_next  = nb;
                                if (nb == 3'd0) begin
                                    cmd = sh;
                                    if (cmd == 8'd0) begin
                                        seek_target_next = {8'd0, current_page_reg};
                                        seek_cd_next = seek_step_reg;
                                        flags_next[tprc_pkg::F_MOTOR_OFF] = 1'b0;
                                        current_page_next = current_page_reg - 8'd1;
                                    end else if (cmd <= tprc_pkg::CMD_FWD_MAX) begin
                                        seek_target_next = 16'(current_page_reg) + 16'(cmd);
                                        seek_cd_next = seek_step_reg;
                                        flags_next[tprc_pkg::F_MOTOR_OFF] = 1'b0;
                                    end else if (cmd <= tprc_pkg::CMD_BACK_MAX) begin
                                        seek_target_next = 16'(current_page_reg)
                                            - 16'(cmd[5:0]);
                                        seek_cd_next = seek_step_reg;
                                        flags_next[tprc_pkg::F_MOTOR_OFF] = 1'b0;
                                    end else if (cmd == tprc_pkg::CMD_NEXT_SLOT) begin
                                        if (5'(slot_reg) + 5'd1 < pages_in_use) begin
                                            slot_next = slot_reg + SW'(1);
                                        end else begin
                                            slot_next = '0;
                                        end
                                        byte_pos_next = '1;
                                        byte_cd_next  = '0;
                                        flags_next[tprc_pkg::F_MOTOR_OFF]  = 1'b0;
                                        flags_next[tprc_pkg::F_PAGE_FOUND] = 1'b1;
                                        state_next = ST_FETCH;
                                    end
                                end
                            end
                            if (i_wdat[4]) begin
                                flags_next[tprc_pkg::F_READY] = 1'b0;
                                bit_cd_next = bit_proc_reg;
                            end
                            if (control_prev_reg[5] && !i_wdat[5]) begin
                                cmd_shift_next = '0;
                                cmd_bits_next  = '0;
                                flags_next[tprc_pkg::F_READY] = 1'b1;
                            end
                            flags_next[tprc_pkg::F_DECODER] = i_wdat[0];
                            flags_next[tprc_pkg::F_IRQ_EN]  = i_wdat[1];
                            irq_next = 1'b0;
                            control_prev_next = i_wdat;
                        end
                    end
                    default: begin
                    end
                endcase
                if (state_next == ST_IDLE) begin
                    out_next       = {7'd0, irq_next, rd};
                    out_valid_next = 1'b1;
                end
            end
            ST_SEARCH: begin
                // Table data for search_reg arrives next cycle; check the previous one.
                if (search_reg != '0 && !found_reg
                    && {1'b0, tab_rdata.page_number} == 9'(current_page_reg) - 9'd1) begin
                    found_next = 1'b1;
                    slot_next  = SW'(search_reg - CW'(1));
                end
                if (search_reg == CW'(pages_in_use) || found_next) begin
                    byte_pos_next = '1;
                    byte_cd_next  = '0;
                    flags_next[tprc_pkg::F_MOTOR_OFF]  = 1'b0;
                    flags_next[tprc_pkg::F_PAGE_FOUND] = 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    search_next = search_reg + CW'(1);
                end
            end
            ST_FETCH: begin
                lead_cd_next   = tab_rdata.lead_in;
                state_next     = ST_IDLE;
                out_next       = {7'd0, irq_reg, 8'd0};
                out_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The fetch cycle needs the entry of the slot that is being selected now.
    always_comb begin
        priority if (state_next == ST_FETCH) begin
            tab_raddr = slot_next;
        end else if (state_reg == ST_SEARCH) begin
            tab_raddr = SW'(search_reg);
        end else begin
            tab_raddr = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            page_count_reg   <= 5'd1;
            seek_step_reg    <= 22'd3000000;
            first_byte_reg   <= 16'd7820;
            byte_cyc_reg     <= 16'd3355;
            bit_proc_reg     <= 16'd100;
            control_prev_reg <= '0;
            cmd_shift_reg    <= '0;
            cmd_bits_reg     <= '0;
            current_page_reg <= '0;
            seek_target_reg  <= '0;
            seek_cd_reg      <= '0;
            byte_cd_reg      <= '0;
            bit_cd_reg       <= '0;
            lead_cd_reg      <= '0;
            slot_reg         <= '0;
            byte_pos_reg     <= '1;
            flags_reg        <= '0;
            irq_reg          <= 1'b0;
            search_reg       <= '0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            control_prev_reg <= control_prev_next;
            cmd_shift_reg    <= cmd_shift_next;
            cmd_bits_reg     <= cmd_bits_next;
            current_page_reg <= current_page_next;
            seek_target_reg  <= seek_target_next;
            seek_cd_reg      <= seek_cd_next;
            byte_cd_reg      <= byte_cd_next;
            bit_cd_reg       <= bit_cd_next;
            lead_cd_reg      <= lead_cd_next;
            slot_reg         <= slot_next;
            byte_pos_reg     <= byte_pos_next;
            flags_reg        <= flags_next;
            irq_reg          <= irq_next;
            search_reg       <= search_next;
            found_reg        <= found_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    tprc_pkg::CFG_PAGE_COUNT: page_count_reg <= cfg_data[4:0];
                    tprc_pkg::CFG_SEEK_STEP:  seek_step_reg  <= cfg_data;
                    tprc_pkg::CFG_FIRST_BYTE: first_byte_reg <= cfg_data[15:0];
                    tprc_pkg::CFG_BYTE:       byte_cyc_reg   <= cfg_data[15:0];
                    tprc_pkg::CFG_BIT_PROC:   bit_proc_reg   <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_tdata;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped");
    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted item not executed");
    a_fetch_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("fetch gave no result");
endmodule

### tb/tb_tape_page_reader_controller.sv
module tb_tape_page_reader_controller;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  req;
        logic [1:0]  ri;
        logic [7:0]  wd;
        logic [3:0]  ent;
        logic [31:0] lead;
        logic [12:0] len;
        logic [7:0]  pnum;
        logic [11:0] off;
    } item_t;

    typedef struct {
        logic [7:0] rd;
        logic       irq;
    } answer_t;

    typedef struct {
        item_t   it;
        bit      fixed;
        answer_t ans;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [21:0] cfg_data;

    tape_page_reader_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Model of the reader, advanced as each item is issued.
    int unsigned  pg_count, seek_step, first_wait, byte_wait, bit_wait;
    logic [7:0]   ctl_prev, cmd_sr, cur_page;
    logic [2:0]   cmd_cnt;
    logic [15:0]  seek_tgt;
    logic [21:0]  seek_cnt;
    logic [15:0]  byte_cnt, bit_cnt;
    logic [31:0]  lead_cnt;
    logic [3:0]   slot;
    int           pos;
    logic [5:0]   flags;
    logic         irq_lvl;
    logic [31:0]  lead_tab [16];
    logic [12:0]  len_tab [16];
    logic [7:0]   pnum_tab [16];
    logic [7:0]   page_mem [65536];
    bit           page_set [65536];

    answer_t expected_q [$];
    int src_idle, snk_idle;
    int issued, received, mismatches;
    int n_ticks, n_cmds, n_data_reads;
    bit failed;

    function automatic int unsigned pages_used();
        if (pg_count < 1) return 1;
        if (pg_count > 16) return 16;
        return pg_count;
    endfunction

    function automatic void start_seek(logic [15:0] t);
        seek_tgt = t;
        seek_cnt = seek_step[21:0];
        flags[tprc_pkg::F_MOTOR_OFF] = 1'b0;
    endfunction

    function automatic void begin_lead_in();
        lead_cnt = lead_tab[slot];
        pos = -1;
        byte_cnt = '0;
        flags[tprc_pkg::F_MOTOR_OFF] = 1'b0;
        flags[tprc_pkg::F_PAGE_FOUND] = 1'b1;
    endfunction

    function automatic void run_command();
        logic [7:0] c;
        c = cmd_sr;
        if (c == 8'h00) begin
            start_seek({8'h00, cur_page});
            cur_page = cur_page - 8'd1;
        end else if (c <= tprc_pkg::CMD_FWD_MAX) begin
            start_seek({8'h00, cur_page} + {8'h00, c});
        end else if (c <= tprc_pkg::CMD_BACK_MAX) begin
            start_seek({8'h00, cur_page} - {8'h00, c & tprc_pkg::CMD_FWD_MAX});
        end else if (c == tprc_pkg::CMD_NEXT_SLOT) begin
            if (int'(slot) + 1 < pages_used()) slot = slot + 4'd1;
            else slot = '0;
            begin_lead_in();
        end
    endfunction

    function automatic void write_control(logic [7:0] v);
        if (ctl_prev[4] && !v[4]) begin
            cmd_sr = {cmd_sr[6:0], v[7]};
            cmd_cnt = cmd_cnt + 3'd1;
            if (cmd_cnt == 3'd0) run_command();
        end
        if (v[4]) begin
            flags[tprc_pkg::F_READY] = 1'b0;
            bit_cnt = bit_wait[15:0];
        end
        if (ctl_prev[5] && !v[5]) begin
            cmd_sr = '0;
            cmd_cnt = '0;
            flags[tprc_pkg::F_READY] = 1'b1;
        end
        flags[tprc_pkg::F_DECODER] = v[0];
        flags[tprc_pkg::F_IRQ_EN] = v[1];
        irq_lvl = 1'b0;
        ctl_prev = v;
    endfunction

    function automatic logic [7:0] read_reg(logic [1:0] r);
        logic [7:0] v;
        case (r)
            tprc_pkg::REG_DATA: begin
                irq_lvl = 1'b0;
                if (pos >= 0 && pos < int'(len_tab[slot]) && pos < tprc_pkg::PAGE_BYTES_DEF)
                    return page_mem[int'(slot) * tprc_pkg::PAGE_BYTES_DEF + pos];
                return tprc_pkg::BYTE_NONE;
            end
            tprc_pkg::REG_STATUS: begin
                v = 8'h10;
                if (flags[tprc_pkg::F_IN_DATA]) v |= 8'h20;
                if (flags[tprc_pkg::F_PAGE_FOUND]) v |= 8'h40;
                if (flags[tprc_pkg::F_DECODER]) v |= 8'h80;
                flags[tprc_pkg::F_PAGE_FOUND] = 1'b0;
                return v;
            end
            tprc_pkg::REG_CONTROL: return flags[tprc_pkg::F_READY] ? 8'h40 : 8'h00;
            default: return 8'h00;
        endcase
    endfunction

    function automatic void tick();
        int sv;
        int unsigned n;
        if (bit_cnt != 0) begin
            bit_cnt = bit_cnt - 16'd1;
            if (bit_cnt == 0) flags[tprc_pkg::F_READY] = 1'b1;
        end
        if (flags[tprc_pkg::F_MOTOR_OFF]) return;
        sv = int'($signed(seek_tgt));
        if (sv != int'(cur_page)) begin
            seek_cnt = seek_cnt - 22'd1;
            if (seek_cnt == 0) begin
                seek_cnt = seek_step[21:0];
                if (sv > int'(cur_page)) cur_page = cur_page + 8'd1;
                else cur_page = cur_page - 8'd1;
                slot = '0;
                n = pages_used();
                for (int i = 0; i < n; i++) begin
                    if (int'(pnum_tab[i]) == int'(cur_page) - 1) begin
                        slot = i[3:0];
                        break;
                    end
                end
                begin_lead_in();
            end
        end else if (lead_cnt > 0) begin
            flags[tprc_pkg::F_IN_DATA] = 1'b1;
            lead_cnt = lead_cnt - 32'd1;
            if (lead_cnt == 0) begin
                byte_cnt = first_wait[15:0];
                irq_lvl = 1'b1;
            end
        end else if (byte_cnt != 0) begin
            byte_cnt = byte_cnt - 16'd1;
            if (byte_cnt == 0) begin
                byte_cnt = byte_wait[15:0];
                pos++;
                if (pos >= int'(len_tab[slot])) begin
                    flags[tprc_pkg::F_PAGE_FOUND] = 1'b0;
                    flags[tprc_pkg::F_IN_DATA] = 1'b0;
                    flags[tprc_pkg::F_MOTOR_OFF] = 1'b1;
                end
                if (flags[tprc_pkg::F_IRQ_EN]) irq_lvl = 1'b1;
            end
        end
    endfunction

    function automatic answer_t predict_answer(item_t it);
        answer_t a;
        a.rd = 8'h00;
        case (it.req)
            tprc_pkg::REQ_TICK: tick();
            tprc_pkg::REQ_READ: a.rd = read_reg(it.ri);
            tprc_pkg::REQ_WRITE: if (it.ri == tprc_pkg::REG_CONTROL) write_control(it.wd);
            tprc_pkg::REQ_ENTRY: begin
                lead_tab[it.ent] = it.lead;
                len_tab[it.ent] = it.len;
                pnum_tab[it.ent] = it.pnum;
            end
            tprc_pkg::REQ_BYTE: begin
                page_mem[int'(it.ent) * tprc_pkg::PAGE_BYTES_DEF + int'(it.off)] = it.wd;
                page_set[int'(it.ent) * tprc_pkg::PAGE_BYTES_DEF + int'(it.off)] = 1'b1;
            end
            default: ;
        endcase
        a.irq = irq_lvl;
        return a;
    endfunction

    // A data read must never touch a page byte that was never loaded.
    function automatic item_t make_safe(item_t it);
        int a;
        a = int'(slot) * tprc_pkg::PAGE_BYTES_DEF + pos;
        if (it.req == tprc_pkg::REQ_READ && it.ri == tprc_pkg::REG_DATA && pos >= 0 &&
            pos < int'(len_tab[slot]) && pos < tprc_pkg::PAGE_BYTES_DEF && !page_set[a])
            it.ri = tprc_pkg::REG_STATUS;
        return it;
    endfunction

    task automatic issue_item(item_t it, bit fixed = 1'b0, answer_t fixed_ans = '{8'h00, 1'b0});
        answer_t a;
        it = make_safe(it);
        a = predict_answer(it);
        if (it.req == tprc_pkg::REQ_TICK) n_ticks++;
        if (it.req == tprc_pkg::REQ_READ && it.ri == tprc_pkg::REG_DATA) n_data_reads++;
        expected_q.insert(expected_q.size(), fixed ? fixed_ans : a);
        issued++;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, it.off, it.pnum, it.len, it.lead, it.ent, it.wd, it.ri, it.req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic item_t blank_item(logic [2:0] req);
        item_t it;
        it = '{req, 2'd0, 8'd0, 4'd0, 32'd0, 13'd0, 8'd0, 12'd0};
        return it;
    endfunction

    task automatic write_ctl(logic [7:0] v);
        item_t it;
        it = blank_item(tprc_pkg::REQ_WRITE);
        it.ri = tprc_pkg::REG_CONTROL;
        it.wd = v;
        issue_item(it);
    endtask

    task automatic shift_command(logic [7:0] c);
        logic [7:0] en;
        en = {6'b0, 2'($urandom_range(3))};
        n_cmds++;
        write_ctl(8'h20 | en);
        write_ctl(en);
        for (int b = 7; b >= 0; b--) begin
            write_ctl(8'h10 | {c[b], 7'b0} | en);
            write_ctl({c[b], 7'b0} | en);
        end
    endtask

    task automatic load_entry(logic [3:0] e, logic [31:0] lead, logic [12:0] len,
                              logic [7:0] pn);
        item_t it;
        it = blank_item(tprc_pkg::REQ_ENTRY);
        it.ent = e;
        it.lead = lead;
        it.len = len;
        it.pnum = pn;
        issue_item(it);
    endtask

    task automatic load_byte(logic [3:0] e, logic [11:0] o, logic [7:0] d);
        item_t it;
        it = blank_item(tprc_pkg::REQ_BYTE);
        it.ent = e;
        it.off = o;
        it.wd = d;
        issue_item(it);
    endtask

    task automatic write_config(logic [2:0] idx, int unsigned val);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (24) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[21:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            tprc_pkg::CFG_PAGE_COUNT: pg_count = val & 32'h1F;
            tprc_pkg::CFG_SEEK_STEP:  seek_step = val & 32'h3FFFFF;
            tprc_pkg::CFG_FIRST_BYTE: first_wait = val & 32'hFFFF;
            tprc_pkg::CFG_BYTE:       byte_wait = val & 32'hFFFF;
            default:                  bit_wait = val & 32'hFFFF;
        endcase
    endtask

    task automatic random_noise();
        item_t it;
        it.req = 3'($urandom_range(7));
        it.ri = 2'($urandom_range(3));
        it.wd = 8'($urandom);
        it.ent = 4'($urandom);
        it.lead = $urandom;
        it.len = 13'($urandom_range(4096));
        it.pnum = 8'($urandom);
        it.off = 12'($urandom);
        issue_item(it);
    endtask

    task automatic random_sequence();
        int k;
        item_t it;
        k = $urandom_range(99);
        if (k < 35) begin
            case ($urandom_range(5))
                0: shift_command(tprc_pkg::CMD_NEXT_SLOT);
                1: shift_command(8'($urandom_range(1, 3)));
                2: shift_command(8'h40 | 8'($urandom_range(1, 3)));
                3: shift_command(8'h00);
                4: shift_command(tprc_pkg::CMD_FWD_MAX);
                default: shift_command(8'($urandom));
            endcase
        end else if (k < 65) begin
            repeat ($urandom_range(1, 30)) begin
                it = blank_item(tprc_pkg::REQ_TICK);
                if ($urandom_range(3) == 0) begin
                    it = blank_item(tprc_pkg::REQ_READ);
                    it.ri = 2'($urandom_range(1));
                end
                issue_item(it);
            end
        end else if (k < 75) begin
            load_entry(4'($urandom), $urandom_range(9) == 0 ? $urandom : $urandom_range(20),
                       $urandom_range(9) == 0 ? 13'($urandom_range(4096))
                                              : 13'($urandom_range(1, 6)),
                       $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(8)));
        end else if (k < 85) begin
            load_byte(4'($urandom), $urandom_range(3) == 0 ? 12'($urandom)
                                                           : 12'($urandom_range(7)),
                      8'($urandom));
        end else begin
            random_noise();
        end
    endtask

    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_tvalid && m_tready) begin
            received++;
            if (expected_q.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rd=%02h irq=%0b", m_tdata[7:0], m_tdata[8]);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[7:0] !== e.rd || m_tdata[8] !== e.irq) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected rd=%02h irq=%0b, got rd=%02h irq=%0b",
                                 received, e.rd, e.irq, m_tdata[7:0], m_tdata[8]);
                end
            end
        end
    end

    int  hold_left;
    bit  held;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!held && issued >= 300) begin
            held = 1'b1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial begin
        #50000000;
        $display("CHECK FAILED");
        $finish;
    end

    row_t rows [$];
    int unsigned cfg_sets [6][5] = '{
        '{4, 3, 5, 2, 3},
        '{16, 1, 1, 1, 1},
        '{0, 2, 8, 3, 2},
        '{31, 4194303, 65535, 65535, 65535},
        '{8, 5, 3, 4, 6},
        '{1, 2, 2, 2, 2}
    };

    function automatic void add_row(item_t it, bit fixed, answer_t ans);
        row_t r;
        r.it = it;
        r.fixed = fixed;
        r.ans = ans;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        item_t it;
        int start;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_idle = 20;
        snk_idle = 60;
        pg_count = 1;
        seek_step = 3000000;
        first_wait = 7820;
        byte_wait = 3355;
        bit_wait = 100;
        ctl_prev = '0;
        cmd_sr = '0;
        cmd_cnt = '0;
        cur_page = '0;
        seek_tgt = '0;
        seek_cnt = '0;
        byte_cnt = '0;
        bit_cnt = '0;
        lead_cnt = '0;
        slot = '0;
        pos = -1;
        flags = '0;
        irq_lvl = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The tables and the first bytes of every page are loaded before anything reads them.
        for (int e = 0; e < 16; e++)
            load_entry(e[3:0], $urandom_range(10), 13'($urandom_range(1, 6)),
                       8'($urandom_range(8)));
        for (int e = 0; e < 16; e++)
            for (int o = 0; o < 6; o++)
                load_byte(e[3:0], o[11:0], 8'($urandom));

        it = blank_item(tprc_pkg::REQ_TICK);
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_READ);
        it.ri = tprc_pkg::REG_DATA;
        add_row(it, 1'b1, '{tprc_pkg::BYTE_NONE, 1'b0});
        it.ri = tprc_pkg::REG_STATUS;
        add_row(it, 1'b1, '{8'h10, 1'b0});
        it.ri = tprc_pkg::REG_CONTROL;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it.ri = tprc_pkg::REG_SPARE;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_WRITE);
        it.ri = tprc_pkg::REG_DATA;
        it.wd = 8'hFF;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it.ri = tprc_pkg::REG_CONTROL;
        it.wd = 8'h23;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it.wd = 8'h03;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_READ);
        it.ri = tprc_pkg::REG_CONTROL;
        add_row(it, 1'b1, '{8'h40, 1'b0});
        it.ri = tprc_pkg::REG_STATUS;
        add_row(it, 1'b1, '{8'h90, 1'b0});
        it = '{3'd5, 2'd3, 8'hFF, 4'hF, 32'hFFFFFFFF, 13'h1FFF, 8'hFF, 12'hFFF};
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it.req = 3'd7;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = '{tprc_pkg::REQ_ENTRY, 2'd0, 8'd0, 4'd15, 32'hFFFFFFFF, 13'd4096, 8'hFF, 12'd0};
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = '{tprc_pkg::REQ_BYTE, 2'd0, 8'hFF, 4'd15, 32'd0, 13'd0, 8'd0, 12'hFFF};
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_WRITE);
        it.ri = tprc_pkg::REG_CONTROL;
        it.wd = 8'h93;
        add_row(it, 1'b0, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_READ);
        it.ri = tprc_pkg::REG_CONTROL;
        add_row(it, 1'b1, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_WRITE);
        it.ri = tprc_pkg::REG_CONTROL;
        it.wd = 8'h83;
        add_row(it, 1'b0, '{8'h00, 1'b0});
        it = blank_item(tprc_pkg::REQ_TICK);
        add_row(it, 1'b0, '{8'h00, 1'b0});
        foreach (rows[i]) issue_item(rows[i].it, rows[i].fixed, rows[i].ans);

        start = issued;
        for (int p = 0; p < 6; p++) begin
            for (int r = 0; r < 5; r++) write_config(r[2:0], cfg_sets[p][r]);
            while (issued - start < (p + 1) * 120) begin
                if (issued - start < 240) begin
                    src_idle = 20;
                    snk_idle = 60;
                end else if (issued - start < 480) begin
                    src_idle = 60;
                    snk_idle = 20;
                end else begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                random_sequence();
            end
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (expected_q.size() != 0) failed = 1'b1;
        $display("Ran %0d items: %0d ticks, %0d commands shifted, %0d data reads.",
                 issued, n_ticks, n_cmds, n_data_reads);
        $display("Six register settings with idle, reversed idle and full rate; %0d mismatches.",
                 mismatches);
        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
